### sv/pif_pkg.sv
// pif_pkg: shared types and constants for the pulse interval framer
// no dependencies

package pif_pkg;

   localparam int TIME_W     = 32;
   localparam int BYTE_W     = 8;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // channel codes
   localparam logic KIND_PULSE   = 1'b0;
   localparam logic KIND_SERVICE = 1'b1;

   // register map
   localparam logic [CSR_ADDR_W-1:0] ADDR_DEBOUNCE = 3'd0;
   localparam logic [TIME_W-1:0]     DEBOUNCE_RESET = 32'd10;

   // frame layout
   localparam logic [BYTE_W-1:0] FRAME_START = 8'hAA;
   localparam logic [BYTE_W-1:0] FRAME_END   = 8'h55;
   localparam int                FRAME_CNT_W = 3;
   localparam logic [FRAME_CNT_W-1:0] POS_START = 3'd0;
   localparam logic [FRAME_CNT_W-1:0] POS_B0    = 3'd1;
   localparam logic [FRAME_CNT_W-1:0] POS_B1    = 3'd2;
   localparam logic [FRAME_CNT_W-1:0] POS_B2    = 3'd3;
   localparam logic [FRAME_CNT_W-1:0] POS_B3    = 3'd4;
   localparam logic [FRAME_CNT_W-1:0] POS_END   = 3'd5;

   // popped ring entry handed from the ring to the framer
   typedef struct packed {
      logic              valid;
      logic [TIME_W-1:0] stamp;
   } pif_pop_type;

endpackage

### sv/pif_channels.sv
// pif_channels: valid/ready channel interfaces for request and response words
// depends on pif_pkg

interface pif_req_if import pif_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              kind;
   logic [TIME_W-1:0] capture_time;

   modport source (output valid, output kind, output capture_time, input ready);
   modport sink   (input valid, input kind, input capture_time, output ready);
endinterface

interface pif_rsp_if import pif_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] frame_byte;
   logic              frame_last;

   modport source (output valid, output frame_byte, output frame_last, input ready);
   modport sink   (input valid, input frame_byte, input frame_last, output ready);
endinterface

### sv/pif_csr.sv
// pif_csr: apb-style register port holding the debounce threshold
// depends on pif_pkg

module pif_csr import pif_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic [TIME_W-1:0]     debounce_threshold
);

   logic [TIME_W-1:0] thr_ff;
   logic [TIME_W-1:0] thr_in;
   logic              wr_hit;

   assign csr_pready = 1'b1;

   // write on the access phase
   assign wr_hit = csr_psel && csr_penable && csr_pwrite && csr_pready
                   && (csr_paddr == ADDR_DEBOUNCE);
   assign thr_in = wr_hit ? csr_pwdata : thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= DEBOUNCE_RESET;
      end else begin
         thr_ff <= thr_in;
      end
   end

   // read back
   always_comb begin
      unique case (csr_paddr)
         ADDR_DEBOUNCE: csr_prdata = thr_ff;
         default:       csr_prdata = '0;
      endcase
   end

   assign debounce_threshold = thr_ff;

endmodule

### sv/pif_ring.sv
// pif_ring: capture ring memory with write and read pointers
// depends on pif_pkg and pif_channels

module pif_ring import pif_pkg::*; #(
   parameter int RING_DEPTH = 128
) (
   input  logic        clock,
   input  logic        reset,
   pif_req_if.sink     req_port,
   input  logic        pop_take,
   output pif_pop_type pop
);

   localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

   logic [TIME_W-1:0] ring_mem [RING_DEPTH];
   logic [TIME_W-1:0] rd_data_ff;
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic              pop_valid_ff, pop_valid_in;
   logic              accept;
   logic              do_write;
   logic              do_read;

   // a new word enters whenever the popped entry is free or leaving
   assign req_port.ready = !pop_valid_ff || pop_take;
   assign accept   = req_port.valid && req_port.ready;
   assign do_write = accept && (req_port.kind == KIND_PULSE);
   // equal pointers read as empty; a word is one kind, so a read never meets a same-cycle write
   assign do_read  = accept && (req_port.kind == KIND_SERVICE) && (rd_ptr_ff != wr_ptr_ff);

   // pointer advance with wrap
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_write) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_read) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
   end

   // popped entry is valid from the cycle after the read
   always_comb begin
      pop_valid_in = pop_valid_ff;
      if (req_port.ready) begin
         pop_valid_in = do_read;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         pop_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         pop_valid_ff <= pop_valid_in;
      end
   end

   // memory write port
   always_ff @(posedge clock) begin
      if (do_write) begin
         ring_mem[wr_ptr_ff] <= req_port.capture_time;
      end
   end

   // memory read port, data held while the framer stalls
   always_ff @(posedge clock) begin
      if (do_read) begin
         rd_data_ff <= ring_mem[rd_ptr_ff];
      end
   end

   assign pop.valid = pop_valid_ff;
   assign pop.stamp = rd_data_ff;

endmodule

### sv/pif_framer.sv
// pif_framer: interval calculation, debounce and six-byte frame output
// depends on pif_pkg and pif_channels

module pif_framer import pif_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  pif_pop_type       pop,
   input  logic [TIME_W-1:0] debounce_threshold,
   output logic              pop_take,
   pif_rsp_if.source         rsp_port
);

   logic [TIME_W-1:0]      prev_ff, prev_in;
   logic [TIME_W-1:0]      delta_ff, delta_in;
   logic [FRAME_CNT_W-1:0] cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   logic [TIME_W-1:0]      delta;
   logic                   has_frame;
   logic                   emit_free;
   logic                   start;

   // interval to the previous capture, wrapping
   assign delta     = pop.stamp - prev_ff;
   assign has_frame = pop.valid && (pop.stamp != '0) && (prev_ff != '0)
                      && (delta > debounce_threshold);

   // emitter can take a new frame when idle or on its closing word
   assign emit_free = !busy_ff || ((cnt_ff == POS_END) && rsp_port.ready);
   assign pop_take  = pop.valid && (!has_frame || emit_free);
   assign start     = pop_take && has_frame;

   always_comb begin
      prev_in  = prev_ff;
      delta_in = delta_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      if (pop_take && (pop.stamp != '0)) begin
         prev_in = pop.stamp;
      end
      if (busy_ff && rsp_port.ready) begin
         if (cnt_ff == POS_END) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff + FRAME_CNT_W'(1);
         end
      end
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = POS_START;
         delta_in = delta;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
         cnt_ff  <= POS_START;
         busy_ff <= 1'b0;
      end else begin
         prev_ff <= prev_in;
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      delta_ff <= delta_in;
   end

   // byte select, interval sent lsb first
   always_comb begin
      case (cnt_ff)
         POS_START: rsp_port.frame_byte = FRAME_START;
         POS_B0:    rsp_port.frame_byte = delta_ff[7:0];
         POS_B1:    rsp_port.frame_byte = delta_ff[15:8];
         POS_B2:    rsp_port.frame_byte = delta_ff[23:16];
         POS_B3:    rsp_port.frame_byte = delta_ff[31:24];
         default:   rsp_port.frame_byte = FRAME_END;
      endcase
   end

   assign rsp_port.valid      = busy_ff;
   assign rsp_port.frame_last = (cnt_ff == POS_END);

endmodule

### sv/pulse_interval_framer.sv
// pulse_interval_framer: top level joining register port, capture ring and framer
// depends on pif_pkg, pif_channels, pif_csr, pif_ring and pif_framer
//
// Usage
// req_port carries words of two kinds: a pulse word writes capture_time into
// the ring, a service word pops the oldest queued capture. Popped non-zero
// times are differenced against the previous one; an interval above the
// debounce threshold leaves on rsp_port as six words: 0xAA, four interval
// bytes lsb first, 0x55 with frame_last set.
// Throughput: one request word per cycle while req_port.ready is high. The
// frame emitter sends one byte per cycle while rsp_port.ready is high; a
// service word whose frame finds the emitter busy waits in the ring's read
// register and holds off further requests until the emitter reaches its
// closing byte. Reset clears the pointers, the previous time, the emitter
// and sets the threshold to 10; ring contents are not cleared. A stalled
// rsp_port holds the current byte stable and backs up into req_port.ready.
// The threshold is written through the csr_ port while the block is idle;
// the user must keep to this, as the block itself does not enforce it.

module pulse_interval_framer import pif_pkg::*; #(
   parameter int RING_DEPTH = 128
) (
   input  logic                  clock,
   input  logic                  reset,
   pif_req_if.sink               req_port,
   pif_rsp_if.source             rsp_port,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [TIME_W-1:0] debounce_threshold;
   pif_pop_type       pop;
   logic              pop_take;

   // register port
   pif_csr u_csr (
      .clock              (clock),
      .reset              (reset),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready),
      .debounce_threshold (debounce_threshold)
   );

   // capture ring
   pif_ring #(
      .RING_DEPTH (RING_DEPTH)
   ) u_ring (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_port),
      .pop_take (pop_take),
      .pop      (pop)
   );

   // interval and frame output
   pif_framer u_framer (
      .clock              (clock),
      .reset              (reset),
      .pop                (pop),
      .debounce_threshold (debounce_threshold),
      .pop_take           (pop_take),
      .rsp_port           (rsp_port)
   );

endmodule

### bench/testbench.sv
// testbench: self-checking bench for pulse_interval_framer, directed table then random words
// depends on pif_pkg, pif_channels and the pulse_interval_framer rtl

`timescale 1ns / 100ps

module testbench;
   import pif_pkg::*;

   localparam int RING_DEPTH      = 128;
   localparam int SETTLE_CYCLES   = 8;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int LIMIT_CYCLES    = 400000;
   localparam int N_ROWS          = 27;

   typedef enum logic [1:0] {ROW_PULSE, ROW_SERVICE, ROW_THRESHOLD} row_op_type;
   typedef enum logic [1:0] {OUT_MODEL, OUT_NONE, OUT_FRAME} row_out_type;

   typedef struct packed {
      row_op_type        op;
      logic [TIME_W-1:0] value;
      row_out_type       out;
   } row_type;

   typedef struct packed {
      logic [BYTE_W-1:0] frame_byte;
      logic              frame_last;
   } frame_word_type;

   logic clock = 1'b0;
   logic reset;

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   pif_req_if req_bus ();
   pif_rsp_if rsp_bus ();

   pulse_interval_framer #(.RING_DEPTH(RING_DEPTH)) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_port    (req_bus),
      .rsp_port    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // clock, 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // interval model state
   logic [TIME_W-1:0]             capture_ring [RING_DEPTH];
   logic [$clog2(RING_DEPTH)-1:0] ring_wr = '0;
   logic [$clog2(RING_DEPTH)-1:0] ring_rd = '0;
   logic [TIME_W-1:0]             last_stamp = '0;
   logic [TIME_W-1:0]             debounce_model = DEBOUNCE_RESET;

   frame_word_type    frame_bytes_due [$];
   int                mismatch_count = 0;
   int                cycle_count = 0;
   int                words_sent = 0;
   int                burst_left = 0;
   logic [TIME_W-1:0] stamp_base = 32'd1000;

   // receiver pattern and hold-off bookkeeping
   int       hold_offs_asked = 0;
   int       hold_offs_done = 0;
   int       hold_left = 0;
   logic [5:0] pattern_age = '0;
   logic [1:0] pattern_mode = 2'd0;

   // directed words: expected frames typed where they are obvious
   row_type directed_rows [N_ROWS] = '{
      '{ROW_SERVICE,   32'd0,         OUT_NONE},    // empty ring
      '{ROW_PULSE,     32'd0,         OUT_MODEL},
      '{ROW_SERVICE,   32'd0,         OUT_NONE},    // zero time dropped
      '{ROW_PULSE,     32'd100,       OUT_MODEL},
      '{ROW_SERVICE,   32'd0,         OUT_NONE},    // first valid time only stored
      '{ROW_PULSE,     32'd110,       OUT_MODEL},
      '{ROW_SERVICE,   32'd0,         OUT_NONE},    // interval equal to threshold
      '{ROW_PULSE,     32'd121,       OUT_MODEL},
      '{ROW_SERVICE,   32'd11,        OUT_FRAME},
      '{ROW_PULSE,     32'd5,         OUT_MODEL},
      '{ROW_PULSE,     32'hFFFF_FFFF, OUT_MODEL},
      '{ROW_SERVICE,   32'hFFFF_FF8C, OUT_FRAME},   // time going backwards wraps
      '{ROW_SERVICE,   32'hFFFF_FFFA, OUT_FRAME},
      '{ROW_SERVICE,   32'd0,         OUT_NONE},    // drained again
      '{ROW_THRESHOLD, 32'd0,         OUT_MODEL},
      '{ROW_PULSE,     32'hFFFF_FFFF, OUT_MODEL},
      '{ROW_SERVICE,   32'd0,         OUT_NONE},    // zero interval, zero threshold
      '{ROW_PULSE,     32'd0,         OUT_MODEL},
      '{ROW_PULSE,     32'd1,         OUT_MODEL},
      '{ROW_SERVICE,   32'd0,         OUT_NONE},
      '{ROW_SERVICE,   32'd2,         OUT_FRAME},   // wraps through zero
      '{ROW_THRESHOLD, 32'hFFFF_FFFF, OUT_MODEL},
      '{ROW_PULSE,     32'h8000_0000, OUT_MODEL},
      '{ROW_SERVICE,   32'd0,         OUT_NONE},    // nothing passes the top threshold
      '{ROW_THRESHOLD, 32'h7FFF_FFFE, OUT_MODEL},
      '{ROW_PULSE,     32'hFFFF_FFFF, OUT_MODEL},
      '{ROW_SERVICE,   32'h7FFF_FFFF, OUT_FRAME}
   };

   // advance the interval model by one word, flag a frame and give its interval
   function automatic bit take_capture(input logic kind, input logic [TIME_W-1:0] stamp,
                                       output logic [TIME_W-1:0] interval);
      logic [TIME_W-1:0] popped;
      interval = '0;
      if (kind == KIND_PULSE) begin
         capture_ring[ring_wr] = stamp;
         ring_wr = ring_wr + 1'b1;
         return 1'b0;
      end
      if (ring_rd == ring_wr) return 1'b0;
      popped = capture_ring[ring_rd];
      ring_rd = ring_rd + 1'b1;
      if (popped == '0) return 1'b0;
      if (last_stamp == '0) begin
         last_stamp = popped;
         return 1'b0;
      end
      interval = popped - last_stamp;
      last_stamp = popped;
      return interval > debounce_model;
   endfunction

   // six bytes of one interval frame
   task automatic queue_frame(input logic [TIME_W-1:0] interval);
      frame_bytes_due.push_back('{FRAME_START, 1'b0});
      for (int b = 0; b < 4; b++) frame_bytes_due.push_back('{interval[8*b +: 8], 1'b0});
      frame_bytes_due.push_back('{FRAME_END, 1'b1});
   endtask

   // offer one request word in bursts with random gaps, return once accepted
   task automatic send_word(input logic kind, input logic [TIME_W-1:0] stamp);
      int  gap;
      bit  took;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = $urandom_range(1, 24);
         if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_bus.valid        <= 1'b1;
      req_bus.kind         <= kind;
      req_bus.capture_time <= stamp;
      do begin
         @(negedge clock);
         took = (req_bus.ready === 1'b1);
         @(posedge clock);
      end while (!took);
      words_sent++;
   endtask

   task automatic send_and_predict(input logic kind, input logic [TIME_W-1:0] stamp);
      logic [TIME_W-1:0] interval;
      send_word(kind, stamp);
      if (take_capture(kind, stamp, interval)) queue_frame(interval);
   endtask

   // stop offering and wait for every expected byte, then let the block settle
   task automatic wait_for_drain();
      req_bus.valid <= 1'b0;
      while (frame_bytes_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // apb write of the debounce threshold, setup then access
   task automatic write_threshold(input logic [TIME_W-1:0] value);
      bit done;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_DEBOUNCE;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do begin
         @(negedge clock);
         done = (csr_pready === 1'b1);
         @(posedge clock);
      end while (!done);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      debounce_model = value;
   endtask

   // interval spread around the current threshold, with some wide ones
   function automatic logic [TIME_W-1:0] pick_interval();
      case ($urandom_range(0, 5))
         0:       return debounce_model;
         1:       return debounce_model + 1'b1;
         2:       return debounce_model - 1'b1;
         3:       return $urandom_range(0, 255);
         4:       return $urandom();
         default: return debounce_model + $urandom_range(2, 5000);
      endcase
   endfunction

   function automatic logic [TIME_W-1:0] make_stamp();
      if ($urandom_range(0, 15) == 0) return '0;
      stamp_base = stamp_base + pick_interval();
      return stamp_base;
   endfunction

   // one random sequence: mostly pulses then services, some noise
   task automatic run_sequence();
      int                count;
      logic              kind;
      logic [TIME_W-1:0] stamp;
      if ($urandom_range(0, 4) == 0) begin
         count = $urandom_range(1, 4);
         repeat (count) begin
            kind  = 1'($urandom_range(0, 1));
            stamp = ($urandom_range(0, 7) == 0) ? '0 : $urandom();
            send_and_predict(kind, stamp);
         end
      end else begin
         count = $urandom_range(1, 6);
         repeat (count) send_and_predict(KIND_PULSE, make_stamp());
         // sometimes one service too many, hitting the empty ring
         count = count + (($urandom_range(0, 4) == 0) ? 1 : 0);
         repeat (count) send_and_predict(KIND_SERVICE, $urandom());
      end
   endtask

   // cycle limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   // receiver: stall pattern is redrawn when pattern_age reaches 63, plus requested hold-offs
   always @(posedge clock) begin
      pattern_age <= pattern_age + 1'b1;
      if (pattern_age == 6'd63) pattern_mode <= 2'($urandom_range(0, 3));
      if (hold_left != 0) begin
         hold_left     <= hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else if (hold_offs_done != hold_offs_asked) begin
         hold_offs_done <= hold_offs_asked;
         hold_left      <= HOLD_OFF_CYCLES;
         rsp_bus.ready  <= 1'b0;
      end else begin
         case (pattern_mode)
            2'd0:    rsp_bus.ready <= 1'b1;
            2'd1:    rsp_bus.ready <= ($urandom_range(0, 3) != 0);
            2'd2:    rsp_bus.ready <= ($urandom_range(0, 3) == 0);
            default: rsp_bus.ready <= ($urandom_range(0, 15) == 0);
         endcase
      end
   end

   // compare each accepted response word with the oldest expected byte
   always @(negedge clock) begin
      frame_word_type want;
      if (reset === 1'b0 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (frame_bytes_due.size() == 0) begin
            $display("%0t: unexpected word, byte %h last %b", $time,
                     rsp_bus.frame_byte, rsp_bus.frame_last);
            mismatch_count++;
         end else begin
            want = frame_bytes_due.pop_front();
            if (rsp_bus.frame_byte !== want.frame_byte) begin
               $display("%0t: frame_byte expected %h actual %h", $time,
                        want.frame_byte, rsp_bus.frame_byte);
               mismatch_count++;
            end
            if (rsp_bus.frame_last !== want.frame_last) begin
               $display("%0t: frame_last expected %b actual %b", $time,
                        want.frame_last, rsp_bus.frame_last);
               mismatch_count++;
            end
         end
      end
   end

   // stimulus
   initial begin
      logic [TIME_W-1:0] phase_threshold [6];
      int                phase_target    [6];
      logic [TIME_W-1:0] interval;
      logic [TIME_W-1:0] stamp;
      bit                has_frame;
      int                phase_start;

      reset                <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.kind         <= KIND_PULSE;
      req_bus.capture_time <= '0;
      csr_psel             <= 1'b0;
      csr_penable          <= 1'b0;
      csr_pwrite           <= 1'b0;
      csr_paddr            <= '0;
      csr_pwdata           <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      for (int r = 0; r < N_ROWS; r++) begin
         case (directed_rows[r].op)
            ROW_THRESHOLD: begin
               wait_for_drain();
               write_threshold(directed_rows[r].value);
            end
            ROW_PULSE: begin
               send_word(KIND_PULSE, directed_rows[r].value);
               void'(take_capture(KIND_PULSE, directed_rows[r].value, interval));
            end
            default: begin
               stamp = $urandom();
               send_word(KIND_SERVICE, stamp);
               has_frame = take_capture(KIND_SERVICE, stamp, interval);
               if (directed_rows[r].out == OUT_FRAME) queue_frame(directed_rows[r].value);
               else if (directed_rows[r].out == OUT_MODEL && has_frame) queue_frame(interval);
            end
         endcase
      end

      // random phases, each under its own threshold
      phase_threshold = '{DEBOUNCE_RESET, 32'd0, $urandom_range(1, 300),
                          32'hFFFF_FFFF, $urandom(), 32'd1000};
      phase_target    = '{0, 16, 8, 4, 8, 8};
      for (int p = 0; p < 6; p++) begin
         wait_for_drain();
         write_threshold(phase_threshold[p]);
         phase_start = words_sent;
         if (p == 0) begin
            // overrun: the write pointer laps the read pointer
            repeat (RING_DEPTH + $urandom_range(0, 2)) send_and_predict(KIND_PULSE, make_stamp());
            repeat (3) send_and_predict(KIND_SERVICE, $urandom());
         end
         // long receiver hold-off while words keep coming, to back up the input
         if (p == 1) hold_offs_asked++;
         while (words_sent - phase_start < phase_target[p]) run_sequence();
      end

      wait_for_drain();
      if (mismatch_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
